[design/ppm_pkg.sv]
package ppm_pkg;

    localparam int QUAT_BITS = 16;
    localparam int PSH = (QUAT_BITS > 31) ? 2 : 0;
    localparam int PROD_W = 2 * QUAT_BITS - PSH;
    localparam int NORM_W = PROD_W + 2;
    localparam int NUM_W = PROD_W + 3;
    localparam int RFRAC = 30;
    localparam int RW = RFRAC + 2;
    localparam int OUT_W = 48;
    localparam int ACC_W = 32 + 33 + 3;

    localparam logic [2:0] IDX_FOCAL_X = 3'd0;
    localparam logic [2:0] IDX_SKEW = 3'd1;
    localparam logic [2:0] IDX_CENTER_X = 3'd2;
    localparam logic [2:0] IDX_FOCAL_Y = 3'd3;
    localparam logic [2:0] IDX_CENTER_Y = 3'd4;

    typedef struct packed {
        logic [31:0] focal_x;
        logic signed [31:0] skew;
        logic [31:0] center_x;
        logic [31:0] focal_y;
        logic [31:0] center_y;
    } intr_t;

    typedef logic signed [RW-1:0] rot_t;

    typedef struct packed {
        rot_t [8:0] r;
        logic signed [2:0][31:0] t;
        logic zero;
    } rot_item_t;

    function automatic logic signed [OUT_W-1:0] sat_round(
        input logic signed [ACC_W-1:0] acc, input logic frac30);
        logic signed [ACC_W:0] rnd;
        logic signed [ACC_W:0] sh;
        begin
            if (frac30)
            begin
                rnd = {acc[ACC_W-1], acc} + ((ACC_W+1)'(1) <<< (RFRAC - 1));
                sh = rnd >>> RFRAC;
            end
            else
            begin
                rnd = {acc[ACC_W-1], acc} + ((ACC_W+1)'(1) <<< 15);
                sh = rnd >>> 16;
            end
            if (sh > $signed({{(ACC_W-OUT_W+2){1'b0}}, {(OUT_W-1){1'b1}}}))
                sat_round = {1'b0, {(OUT_W-1){1'b1}}};
            else if (sh < -$signed({{(ACC_W-OUT_W+1){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}}))
                sat_round = {1'b1, {(OUT_W-1){1'b0}}};
            else
                sat_round = sh[OUT_W-1:0];
        end
    endfunction

endpackage

[design/ppm_div.sv]
module ppm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [ppm_pkg::NUM_W-1:0]   num,
    input  logic        [ppm_pkg::NORM_W-1:0]  norm,
    output logic                               out_valid,
    output ppm_pkg::rot_t                      quo
);
    localparam int STEPS = ppm_pkg::RFRAC + 1;
    localparam int MW = ppm_pkg::NORM_W + 1;

    logic [STEPS+1:0] v_reg;
    logic [STEPS:0] neg_reg;
    logic [STEPS:0] big_reg;
    logic [STEPS:0][MW-1:0] rem_reg;
    logic [STEPS:0][MW-1:0] n_reg;
    logic [STEPS:0][STEPS-1:0] q_reg;
    ppm_pkg::rot_t quo_next;
    ppm_pkg::rot_t quo_reg;

    logic [ppm_pkg::NUM_W-1:0] mag;
    assign mag = num[ppm_pkg::NUM_W-1] ? ppm_pkg::NUM_W'(-num) : ppm_pkg::NUM_W'(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STEPS:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0] <= num[ppm_pkg::NUM_W-1];
            big_reg[0] <= MW'(mag) >= MW'(norm);
            rem_reg[0] <= MW'(mag);
            n_reg[0] <= MW'(norm);
            q_reg[0] <= '0;
            for (int i = 0; i < STEPS; i++)
            begin
                logic [MW:0] sh;
                sh = {rem_reg[i], 1'b0};
                neg_reg[i+1] <= neg_reg[i];
                big_reg[i+1] <= big_reg[i];
                n_reg[i+1] <= n_reg[i];
                if (sh >= {1'b0, n_reg[i]})
                begin
                    rem_reg[i+1] <= MW'(sh - {1'b0, n_reg[i]});
                    q_reg[i+1] <= {q_reg[i][STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= MW'(sh);
                    q_reg[i+1] <= {q_reg[i][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    logic [ppm_pkg::RW-1:0] qm;
    always_comb
    begin
        if (big_reg[STEPS])
            qm = ppm_pkg::RW'(1) << ppm_pkg::RFRAC;
        else
            qm = ppm_pkg::RW'((STEPS+1)'(q_reg[STEPS]) + (STEPS+1)'(1)) >> 1;
        quo_next = neg_reg[STEPS] ? -$signed(qm) : $signed(qm);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;
    assign out_valid = v_reg[STEPS+1];
endmodule

[design/ppm_rot.sv]
module ppm_rot (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic signed [3:0][ppm_pkg::QUAT_BITS-1:0] q,
    input  logic signed [2:0][31:0]               t,
    output logic                                  out_valid,
    output ppm_pkg::rot_item_t                    item
);
    localparam int PW = ppm_pkg::PROD_W;
    localparam int DEPTH = ppm_pkg::RFRAC + 3;

    logic v1_reg;
    logic signed [9:0][PW-1:0] p_reg;
    logic signed [2:0][31:0] t1_reg;
    logic v2_reg;
    logic signed [8:0][ppm_pkg::NUM_W-1:0] num_reg;
    logic [ppm_pkg::NORM_W-1:0] n_reg;
    logic signed [2:0][31:0] t2_reg;

    function automatic logic signed [PW-1:0] pr(
        input logic signed [ppm_pkg::QUAT_BITS-1:0] a,
        input logic signed [ppm_pkg::QUAT_BITS-1:0] b);
        logic signed [2*ppm_pkg::QUAT_BITS-1:0] m;
        begin
            m = a * b;
            pr = PW'(m >>> ppm_pkg::PSH);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= pr(q[0], q[0]);
            p_reg[1] <= pr(q[1], q[1]);
            p_reg[2] <= pr(q[2], q[2]);
            p_reg[3] <= pr(q[3], q[3]);
            p_reg[4] <= pr(q[0], q[1]);
            p_reg[5] <= pr(q[2], q[3]);
            p_reg[6] <= pr(q[0], q[2]);
            p_reg[7] <= pr(q[1], q[3]);
            p_reg[8] <= pr(q[1], q[2]);
            p_reg[9] <= pr(q[0], q[3]);
            t1_reg <= t;
            num_reg[0] <= ppm_pkg::NUM_W'($signed(p_reg[0]))
                - ppm_pkg::NUM_W'($signed(p_reg[1]))
                - ppm_pkg::NUM_W'($signed(p_reg[2])) + ppm_pkg::NUM_W'($signed(p_reg[3]));
            num_reg[4] <= -ppm_pkg::NUM_W'($signed(p_reg[0]))
                + ppm_pkg::NUM_W'($signed(p_reg[1]))
                - ppm_pkg::NUM_W'($signed(p_reg[2])) + ppm_pkg::NUM_W'($signed(p_reg[3]));
            num_reg[8] <= -ppm_pkg::NUM_W'($signed(p_reg[0]))
                - ppm_pkg::NUM_W'($signed(p_reg[1]))
                + ppm_pkg::NUM_W'($signed(p_reg[2])) + ppm_pkg::NUM_W'($signed(p_reg[3]));
            num_reg[3] <= (ppm_pkg::NUM_W'($signed(p_reg[4]))
                + ppm_pkg::NUM_W'($signed(p_reg[5]))) <<< 1;
            num_reg[1] <= (ppm_pkg::NUM_W'($signed(p_reg[4]))
                - ppm_pkg::NUM_W'($signed(p_reg[5]))) <<< 1;
            num_reg[6] <= (ppm_pkg::NUM_W'($signed(p_reg[6]))
                - ppm_pkg::NUM_W'($signed(p_reg[7]))) <<< 1;
            num_reg[2] <= (ppm_pkg::NUM_W'($signed(p_reg[6]))
                + ppm_pkg::NUM_W'($signed(p_reg[7]))) <<< 1;
            num_reg[7] <= (ppm_pkg::NUM_W'($signed(p_reg[8]))
                + ppm_pkg::NUM_W'($signed(p_reg[9]))) <<< 1;
            num_reg[5] <= (ppm_pkg::NUM_W'($signed(p_reg[8]))
                - ppm_pkg::NUM_W'($signed(p_reg[9]))) <<< 1;
            n_reg <= ppm_pkg::NORM_W'($unsigned(p_reg[0])) + ppm_pkg::NORM_W'($unsigned(p_reg[1]))
                + ppm_pkg::NORM_W'($unsigned(p_reg[2])) + ppm_pkg::NORM_W'($unsigned(p_reg[3]));
            t2_reg <= t1_reg;
        end
    end

    logic [8:0] dv;
    ppm_pkg::rot_t [8:0] dq;

    for (genvar g = 0; g < 9; g++)
    begin : g_div
        ppm_div u_div (
            .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(v2_reg),
            .num(num_reg[g]), .norm(n_reg),
            .out_valid(dv[g]), .quo(dq[g])
        );
    end

    logic [DEPTH-1:0][2:0][31:0] td_reg;
    logic [DEPTH-1:0] zd_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            td_reg[0] <= t2_reg;
            zd_reg[0] <= n_reg == '0;
            for (int i = 1; i < DEPTH; i++)
            begin
                td_reg[i] <= td_reg[i-1];
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    assign out_valid = dv[0];
    assign item.r = dq;
    assign item.t = td_reg[ppm_pkg::RFRAC+2];
    assign item.zero = zd_reg[ppm_pkg::RFRAC+2];
endmodule

[design/ppm_row.sv]
module ppm_row (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  ppm_pkg::rot_item_t      item,
    input  ppm_pkg::intr_t          kmat,
    output logic                    out_valid,
    output logic [3:0][ppm_pkg::OUT_W-1:0] row_cols,
    output logic [1:0]              row_idx,
    output logic                    zero
);
    localparam int AW = ppm_pkg::ACC_W;

    logic [1:0] ph_reg;
    ppm_pkg::rot_item_t it_reg;
    logic v1_reg;
    logic [1:0] r1_reg;
    logic z1_reg;
    logic signed [3:0][2:0][AW-1:0] pp_reg;
    logic v2_reg;
    logic [1:0] r2_reg;
    logic z2_reg;
    logic [3:0][ppm_pkg::OUT_W-1:0] o_reg;

    ppm_pkg::rot_item_t cur;
    assign cur = (ph_reg == 2'd0) ? item : it_reg;
    logic act;
    assign act = (ph_reg != 2'd0) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= 2'd0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= act;
            v2_reg <= v1_reg;
            if (act)
                ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
        end
    end

    logic signed [2:0][32:0] k;
    always_comb
    begin
        unique case (ph_reg)
            2'd0:
            begin
                k[0] = {1'b0, kmat.focal_x};
                k[1] = {kmat.skew[31], kmat.skew};
                k[2] = {1'b0, kmat.center_x};
            end
            2'd1:
            begin
                k[0] = '0;
                k[1] = {1'b0, kmat.focal_y};
                k[2] = {1'b0, kmat.center_y};
            end
            default:
            begin
                k[0] = '0;
                k[1] = '0;
                k[2] = 33'sd65536;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ph_reg == 2'd0)
                it_reg <= item;
            r1_reg <= ph_reg;
            z1_reg <= cur.zero;
            for (int c = 0; c < 3; c++)
                for (int j = 0; j < 3; j++)
                    pp_reg[c][j] <= AW'($signed(k[j])) * AW'(cur.r[j*3+c]);
            for (int j = 0; j < 3; j++)
                pp_reg[3][j] <= AW'($signed(k[j])) * AW'($signed(cur.t[j]));
            r2_reg <= r1_reg;
            z2_reg <= z1_reg;
            for (int c = 0; c < 4; c++)
                o_reg[c] <= z1_reg ? '0 : ppm_pkg::sat_round(
                    pp_reg[c][0] + pp_reg[c][1] + pp_reg[c][2], c < 3);
        end
    end

    assign out_valid = v2_reg;
    assign row_cols = o_reg;
    assign row_idx = r2_reg;
    assign zero = z2_reg;
endmodule

[design/pose_to_projection_matrix_top.sv]
// Pose to projection matrix. Accepts poses and emits the three rows of
// P = K*[R|t] as three output transactions, row 0 first. The path to row 0 is
// mostly the 31-step restoring divider pipeline that normalizes each rotation entry;
// the row multiplier stage emits one row per cycle unless the output stalls, so the
// input drops ready after each accepted pose. A stall on the output freezes the whole
// pipeline. Write the intrinsic registers only while no transaction is in flight.
module pose_to_projection_matrix_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, trans_x, trans_y, trans_z
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // proj_col0, proj_col1, proj_col2, proj_col3, row_index
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // zero_norm
    output logic         m_axis_tuser
);
    localparam int QB = ppm_pkg::QUAT_BITS;

    ppm_pkg::intr_t k_reg;
    logic [2:0] idx;
    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= '0;
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                ppm_pkg::IDX_FOCAL_X: k_reg.focal_x <= pwdata;
                ppm_pkg::IDX_SKEW: k_reg.skew <= pwdata;
                ppm_pkg::IDX_CENTER_X: k_reg.center_x <= pwdata;
                ppm_pkg::IDX_FOCAL_Y: k_reg.focal_y <= pwdata;
                ppm_pkg::IDX_CENTER_Y: k_reg.center_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ppm_pkg::IDX_FOCAL_X: prdata = k_reg.focal_x;
            ppm_pkg::IDX_SKEW: prdata = k_reg.skew;
            ppm_pkg::IDX_CENTER_X: prdata = k_reg.center_x;
            ppm_pkg::IDX_FOCAL_Y: prdata = k_reg.focal_y;
            ppm_pkg::IDX_CENTER_Y: prdata = k_reg.center_y;
            default: prdata = '0;
        endcase
    end

    logic out_v_reg;
    logic adv;
    assign adv = !out_v_reg || m_axis_tready;

    logic [1:0] gap_reg;
    logic acc_in;
    assign s_axis_tready = adv && (gap_reg == 2'd0);
    assign acc_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= 2'd0;
        else if (adv)
        begin
            if (acc_in)
                gap_reg <= 2'd2;
            else if (gap_reg != 2'd0)
                gap_reg <= gap_reg - 2'd1;
        end
    end

    logic signed [3:0][QB-1:0] q;
    logic signed [2:0][31:0] t;
    assign q[0] = s_axis_tdata[QB-1:0];
    assign q[1] = s_axis_tdata[2*QB-1:QB];
    assign q[2] = s_axis_tdata[3*QB-1:2*QB];
    assign q[3] = s_axis_tdata[4*QB-1:3*QB];
    assign t[0] = s_axis_tdata[4*QB+31:4*QB];
    assign t[1] = s_axis_tdata[4*QB+63:4*QB+32];
    assign t[2] = s_axis_tdata[4*QB+95:4*QB+64];

    logic rv;
    ppm_pkg::rot_item_t ritem;
    ppm_rot u_rot (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(acc_in),
        .q(q), .t(t), .out_valid(rv), .item(ritem)
    );

    logic ov;
    logic [3:0][ppm_pkg::OUT_W-1:0] cols;
    logic [1:0] ridx;
    logic rz;
    ppm_row u_row (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(rv), .item(ritem), .kmat(k_reg),
        .out_valid(ov), .row_cols(cols), .row_idx(ridx), .zero(rz)
    );

    logic [199:0] d_reg;
    logic l_reg;
    logic u_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= ov;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= {6'd0, ridx, cols[3], cols[2], cols[1], cols[0]};
            l_reg <= ridx == 2'd2;
            u_reg <= rz;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = d_reg;
    assign m_axis_tlast = l_reg;
    assign m_axis_tuser = u_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[193:192] == 2'd2)
    else $error("last row index");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[191:0] == '0)
    else $error("zero norm row not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input gap");
endmodule

[dv/tb_pose_to_projection_matrix_top.sv]
`timescale 1ns / 1ps

module tb_pose_to_projection_matrix_top;

    typedef struct {
        logic [47:0] col [4];
        logic [1:0]  row;
        logic        last;
        logic        zero;
    } proj_row_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // quat_x, quat_y, quat_z, quat_w, trans_x, trans_y, trans_z
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // proj_col0, proj_col1, proj_col2, proj_col3, row_index
    logic [199:0] m_axis_tdata;
    logic         m_axis_tlast;
    // zero_norm
    logic         m_axis_tuser;

    logic [159:0] pose_queue [$];
    proj_row_t    row_queue [$];
    longint       k_focal_x, k_skew, k_center_x, k_focal_y, k_center_y;
    int           issued_cnt, accepted_cnt, rows_checked, zero_poses, err_cnt;
    int           idle_mode, hold_req, hold_seen, hold_cnt;
    bit           run_done;

    pose_to_projection_matrix_top dut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch row %0d %s: got %h want %h", rows_checked, what, got, want);
        err_cnt++;
    endtask

    function automatic longint normalize(input longint num, input longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        if (mag >= n)
            q = 64'sd1 <<< 30;
        else
            q = (((mag <<< 31) / n) + 1) >>> 1;
        return (num < 0) ? -q : q;
    endfunction

    function automatic void predict_rows(input logic [159:0] d);
        longint x, y, z, w, n;
        longint xx, yy, zz, ww, xy, zw, xz, yw, yz, xw;
        longint num [3][3];
        longint m [3][4];
        longint k [3][3];
        logic signed [79:0] acc, ka, ma;
        logic signed [79:0] lim;
        proj_row_t r;
        int sh;
        x = $signed(d[15:0]);
        y = $signed(d[31:16]);
        z = $signed(d[47:32]);
        w = $signed(d[63:48]);
        xx = x * x; yy = y * y; zz = z * z; ww = w * w;
        xy = x * y; zw = z * w; xz = x * z; yw = y * w; yz = y * z; xw = x * w;
        n = xx + yy + zz + ww;
        num[0][0] = xx - yy - zz + ww;
        num[1][1] = -xx + yy - zz + ww;
        num[2][2] = -xx - yy + zz + ww;
        num[1][0] = 2 * (xy + zw); num[0][1] = 2 * (xy - zw);
        num[2][0] = 2 * (xz - yw); num[0][2] = 2 * (xz + yw);
        num[2][1] = 2 * (yz + xw); num[1][2] = 2 * (yz - xw);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                m[i][j] = (n == 0) ? 0 : normalize(num[i][j], n);
            m[i][3] = $signed(d[64 + 32*i +: 32]);
        end
        k[0][0] = k_focal_x; k[0][1] = k_skew; k[0][2] = k_center_x;
        k[1][0] = 0; k[1][1] = k_focal_y; k[1][2] = k_center_y;
        k[2][0] = 0; k[2][1] = 0; k[2][2] = 64'sd65536;
        lim = 80'sh7FFF_FFFF_FFFF;
        if (n == 0)
            zero_poses++;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                acc = '0;
                sh = (c < 3) ? 30 : 16;
                for (int j = 0; j < 3; j++)
                begin
                    ka = k[i][j];
                    ma = m[j][c];
                    acc = acc + ka * ma;
                end
                acc = (acc + (80'sd1 <<< (sh - 1))) >>> sh;
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim - 1)
                    acc = -lim - 1;
                r.col[c] = (n == 0) ? 48'd0 : acc[47:0];
            end
            r.row = i[1:0];
            r.last = (i == 2);
            r.zero = (n == 0);
            row_queue.insert(row_queue.size(), r);
        end
    endfunction

    // accept side
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_rows(s_axis_tdata);
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    // pose driver
    always @(negedge clk)
    begin
        if (rst_n && issued_cnt == accepted_cnt)
        begin
            if (pose_queue.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 35) &&
                !(idle_mode == 1 && $urandom_range(99) < 66))
            begin
                s_axis_tdata <= pose_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                issued_cnt <= issued_cnt + 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt <= 400;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n || hold_cnt > 0 || hold_req != hold_seen)
            m_axis_tready <= 1'b0;
        else if (idle_mode == 0)
            m_axis_tready <= ($urandom_range(99) >= 66);
        else if (idle_mode == 1)
            m_axis_tready <= ($urandom_range(99) >= 35);
        else
            m_axis_tready <= 1'b1;
    end

    // row checker
    always @(posedge clk)
    begin
        proj_row_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (row_queue.size() == 0)
            begin
                $display("unexpected row transaction %h", m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                want = row_queue.pop_front();
                for (int c = 0; c < 4; c++)
                    if (m_axis_tdata[48*c +: 48] !== want.col[c])
                        report($sformatf("proj_col%0d", c), m_axis_tdata[48*c +: 48], want.col[c]);
                if (m_axis_tdata[193:192] !== want.row)
                    report("row_index", m_axis_tdata[193:192], want.row);
                if (m_axis_tlast !== want.last)
                    report("last_row", m_axis_tlast, want.last);
                if (m_axis_tuser !== want.zero)
                    report("zero_norm", m_axis_tuser, want.zero);
                rows_checked++;
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            ppm_pkg::IDX_FOCAL_X:  k_focal_x = value;
            ppm_pkg::IDX_SKEW:     k_skew = $signed(value);
            ppm_pkg::IDX_CENTER_X: k_center_x = value;
            ppm_pkg::IDX_FOCAL_Y:  k_focal_y = value;
            ppm_pkg::IDX_CENTER_Y: k_center_y = value;
            default: ;
        endcase
    endtask

    task automatic load_intrinsics(input logic [31:0] fx, input logic [31:0] sk,
                                   input logic [31:0] cx, input logic [31:0] fy,
                                   input logic [31:0] cy);
        apb_write(ppm_pkg::IDX_FOCAL_X, fx);
        apb_write(ppm_pkg::IDX_SKEW, sk);
        apb_write(ppm_pkg::IDX_CENTER_X, cx);
        apb_write(ppm_pkg::IDX_FOCAL_Y, fy);
        apb_write(ppm_pkg::IDX_CENTER_Y, cy);
    endtask

    task automatic wait_drained();
        wait (pose_queue.size() == 0 && issued_cnt == accepted_cnt && row_queue.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($signed($urandom_range(200)) - 100);
            2: return 16'($signed($urandom_range(20000)) - 10000);
            default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_trans();
        if ($urandom_range(1))
            return $urandom();
        return 32'($signed($urandom_range(2000000)) - 1000000);
    endfunction

    task automatic push_random(input int count);
        logic [159:0] d;
        for (int i = 0; i < count; i++)
        begin
            d = {rand_trans(), rand_trans(), rand_trans(),
                 rand_quat(), rand_quat(), rand_quat(), rand_quat()};
            if ($urandom_range(19) == 0)
                d[63:0] = '0;
            pose_queue.insert(pose_queue.size(), d);
        end
    endtask

    task automatic queue_pose(input logic [159:0] d);
        pose_queue.insert(pose_queue.size(), d);
    endtask

    // quat fields x, y, z, w then trans x, y, z
    function automatic logic [159:0] pose(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] z, input logic [15:0] w,
                                          input logic [31:0] tx, input logic [31:0] ty,
                                          input logic [31:0] tz);
        return {tz, ty, tx, w, z, y, x};
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        issued_cnt = 0; accepted_cnt = 0; rows_checked = 0; zero_poses = 0; err_cnt = 0;
        hold_req = 0; hold_seen = 0; hold_cnt = 0; idle_mode = 0; run_done = 0;
        k_focal_x = 0; k_skew = 0; k_center_x = 0; k_focal_y = 0; k_center_y = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_intrinsics(32'd500 << 16, 32'h0000_8000, 32'd320 << 16, 32'd480 << 16,
                        32'd240 << 16);
        queue_pose(pose(0, 0, 0, 0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        queue_pose(pose(0, 0, 0, 16'h7FFF, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        queue_pose(pose(0, 0, 0, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_pose(pose(16'h8000, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        queue_pose(pose(0, 16'h8000, 0, 0, 0, 0, 0));
        queue_pose(pose(0, 0, 16'h8000, 0, 32'hFFFF_FFFF, 0, 32'h1));
        queue_pose(pose(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 2, 3));
        queue_pose(pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 32'hFFFF_0000));
        queue_pose(pose(16'h0001, 0, 0, 0, 0, 0, 0));
        queue_pose(pose(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 5, 6, 7));
        queue_pose(pose(16'h4000, 16'hC000, 16'h2000, 16'h6000, 32'h1234_5678,
                        32'h8765_4321, 32'hDEAD_BEEF));
        queue_pose(pose(16'h0003, 16'h0002, 16'h0001, 0, 0, 0, 0));
        wait (pose_queue.size() == 0);
        hold_req = hold_req + 1;
        push_random(30);
        wait_drained();

        load_intrinsics(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF);
        push_random(55);
        wait_drained();

        idle_mode = 1;
        load_intrinsics(32'd0, 32'h8000_0000, 32'd0, 32'd1, 32'd0);
        push_random(60);
        wait_drained();

        idle_mode = 2;
        load_intrinsics($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        push_random(30);
        wait_drained();
        push_random(40);
        wait (pose_queue.size() == 0 && issued_cnt == accepted_cnt && row_queue.size() == 0);
        repeat (60) @(posedge clk);

        $display("%0d poses sent, %0d with zero length, %0d rows checked", accepted_cnt,
                 zero_poses, rows_checked);
        $display("covered four intrinsic settings, field extremes, stalls and hold-offs");
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[pose_to_projection_matrix_top.f]
design/ppm_pkg.sv
design/ppm_div.sv
design/ppm_rot.sv
design/ppm_row.sv
design/pose_to_projection_matrix_top.sv
dv/tb_pose_to_projection_matrix_top.sv
